[hw/rtl/hot_entry_profiler_top_k_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the hot entry profiler
// Immediate-consequence and next-cycle implication checks, compiled out in
// synthesis.
// ----------------------------------------------------------------------------
`ifndef HOT_ENTRY_PROFILER_TOP_K_UNIT_ASSERT_SVH
`define HOT_ENTRY_PROFILER_TOP_K_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HEP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hep assertion failed");
`define HEP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hep assertion failed");
`else
`define HEP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define HEP_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/hep_pkg.sv]
// ----------------------------------------------------------------------------
// hep_pkg
// Shared types and constants of the hot entry profiler.
// ----------------------------------------------------------------------------
package hep_pkg;

  localparam int unsigned ENTRY_COUNT_DEF = 1024;
  localparam int unsigned TOP_MAX_DEF     = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [10:0] ENTRIES_IN_USE_RST = 11'd1024;
  localparam logic [4:0]  REPORT_LIMIT_RST   = 5'd16;

  localparam logic OP_NOTE   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [0:0] {
    REG_ENTRIES_IN_USE = 1'b0,
    REG_REPORT_LIMIT   = 1'b1
  } reg_idx_e;

  // one queued transaction
  typedef struct packed {
    logic        report;
    logic [11:0] idx;
    logic [31:0] dur;
  } item_t;

  // back end status seen by the front end
  typedef struct packed {
    logic init_busy;
  } status_t;

endpackage

[hw/rtl/hot_entry_profiler_top_k_unit.sv]
// ----------------------------------------------------------------------------
// hot_entry_profiler_top_k_unit
// Per-entry call/time profiling counters with a ranked top-k delta report.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps its counter bank to zero with
// in_stall_o high (APB writes still work). A note transaction (operation 0)
// adds one call and its duration to an entry; while the back end is idle,
// notes run one per cycle through a read-modify-write on the bank RAM,
// with the previous write forwarded. Notes with indices at or above
// ENTRY_COUNT are dropped at the input. A report transaction (operation 1)
// is picked up, then one bank pass over min(entries_in_use, ENTRY_COUNT)
// entries finds whether any time delta is nonzero, a second pass over the
// same entries ranks one entry per cycle into the top list, results stream
// out one per cycle unless the result side stalls, then a sweep zeroes
// the bank (the bank holds deltas since the last report, so this is the
// snapshot). A report with report_limit zero returns one empty result at
// once and leaves the counters alone. A short input queue keeps taking
// transactions while the back end is busy; results sit in an output
// register.
// ----------------------------------------------------------------------------
module hot_entry_profiler_top_k_unit #(
  parameter int unsigned ENTRY_COUNT = hep_pkg::ENTRY_COUNT_DEF,
  parameter int unsigned TOP_MAX     = hep_pkg::TOP_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input transactions
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [11:0] entry_index_i,
  input  logic [31:0] duration_i,
  // result transactions
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  ranked_index_o,
  output logic [31:0] call_delta_o,
  output logic [63:0] time_delta_o,
  output logic        ranked_by_time_o,
  output logic        empty_res_o,
  output logic        last_o
);

  logic [10:0]       eiu_q;
  logic [4:0]        rl_q;
  logic              wr_en;
  hep_pkg::reg_idx_e reg_sel;
  hep_pkg::status_t  status;
  hep_pkg::item_t    q_item;
  logic              q_valid, q_pop;

  // registers sit at byte offsets 0 and 4; low address bits are ignored
  assign pready  = 1'b1;
  assign reg_sel = hep_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    case (reg_sel)
      hep_pkg::REG_ENTRIES_IN_USE: prdata = {21'h0, eiu_q};
      hep_pkg::REG_REPORT_LIMIT:   prdata = {27'h0, rl_q};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eiu_q <= hep_pkg::ENTRIES_IN_USE_RST;
      rl_q  <= hep_pkg::REPORT_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        hep_pkg::REG_ENTRIES_IN_USE: eiu_q <= pwdata[10:0];
        hep_pkg::REG_REPORT_LIMIT:   rl_q  <= pwdata[4:0];
        default: begin
        end
      endcase
    end
  end

  hep_front #(.ENTRY_COUNT(ENTRY_COUNT)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .duration_i    (duration_i),
    .status_i      (status),
    .q_pop_i       (q_pop),
    .q_valid_o     (q_valid),
    .q_item_o      (q_item)
  );

  hep_engine #(.ENTRY_COUNT(ENTRY_COUNT), .TOP_MAX(TOP_MAX)) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .status_o         (status),
    .entries_in_use_i (eiu_q),
    .report_limit_i   (rl_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ranked_index_o   (ranked_index_o),
    .call_delta_o     (call_delta_o),
    .time_delta_o     (time_delta_o),
    .ranked_by_time_o (ranked_by_time_o),
    .empty_res_o      (empty_res_o),
    .last_o           (last_o)
  );

endmodule

[hw/rtl/hep_ram.sv]
// ----------------------------------------------------------------------------
// hep_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hep_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hw/rtl/hep_front.sv]
// ----------------------------------------------------------------------------
// hep_front
// Input side: drops out-of-range notes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module hep_front #(
  parameter int unsigned ENTRY_COUNT = hep_pkg::ENTRY_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [11:0]       entry_index_i,
  input  logic [31:0]       duration_i,
  input  hep_pkg::status_t  status_i,
  input  logic              q_pop_i,
  output logic              q_valid_o,
  output hep_pkg::item_t    q_item_o
);

  localparam int unsigned QD  = hep_pkg::QUEUE_DEPTH;
  localparam int unsigned QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned QCW = $clog2(QD + 1);

  hep_pkg::item_t    mem_q [QD];
  logic [QAW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [QCW-1:0]    cnt_q, cnt_d;
  logic              full, keep, push, pop;

  assign full       = (cnt_q == QCW'(QD));
  assign in_stall_o = full || status_i.init_busy;
  assign keep       = (operation_i == hep_pkg::OP_REPORT) ||
                      ({1'b0, entry_index_i} < 13'(ENTRY_COUNT));
  assign push       = in_valid_i && !in_stall_o && keep;
  assign pop        = q_pop_i && q_valid_o;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == QAW'(QD - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QAW'(QD - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{report: operation_i, idx: entry_index_i, dur: duration_i};
    end
  end

endmodule

[hw/rtl/hep_engine.sv]
// ----------------------------------------------------------------------------
// hep_engine
// Back end: delta bank updates, two-pass ranked report, result output and
// the bank clearing sweep.
// ----------------------------------------------------------------------------
`include "hot_entry_profiler_top_k_unit_assert.svh"

module hep_engine #(
  parameter int unsigned ENTRY_COUNT = hep_pkg::ENTRY_COUNT_DEF,
  parameter int unsigned TOP_MAX     = hep_pkg::TOP_MAX_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  hep_pkg::item_t    q_item_i,
  output logic              q_pop_o,
  output hep_pkg::status_t  status_o,
  input  logic [10:0]       entries_in_use_i,
  input  logic [4:0]        report_limit_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [9:0]        ranked_index_o,
  output logic [31:0]       call_delta_o,
  output logic [63:0]       time_delta_o,
  output logic              ranked_by_time_o,
  output logic              empty_res_o,
  output logic              last_o
);

  localparam int unsigned IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned CW = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned TW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
  localparam int unsigned LW = $clog2(TOP_MAX + 1);
  localparam int unsigned DW = 96;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_DETECT, ST_RANK, ST_EMIT, ST_CLEAR
  } state_e;

  state_e st_q, st_d;

  // bank: {time delta, call delta}
  logic          ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // note pipeline and forwarding
  logic          nb_v_q, nb_v_d;
  logic [IW-1:0] nb_addr_q;
  logic [31:0]   nb_dur_q;
  logic          fwd_v_q;
  logic [IW-1:0] fwd_addr_q;
  logic [DW-1:0] fwd_data_q;
  logic [DW-1:0] nb_cur, nb_new;

  // report control
  logic [CW-1:0] addr_q, addr_d, cnt_q, cnt_d;
  logic [LW-1:0] lim_q, lim_d, fill_q, fill_d, emit_q, emit_d;
  logic          rv_q, rv_d;
  logic [IW-1:0] ridx_q;
  logic          timed_q, timed_d;
  logic          q_pop, out_free, out_load;

  // top list
  logic [IW-1:0] tord_q [TOP_MAX];
  logic [31:0]   tcall_q [TOP_MAX];
  logic [63:0]   ttime_q [TOP_MAX];
  logic [IW-1:0] sh_ord [TOP_MAX];
  logic [31:0]   sh_call [TOP_MAX];
  logic [63:0]   sh_time [TOP_MAX];
  logic [TOP_MAX-1:0] ge, ge_prev;
  logic [63:0]   key_in;
  logic          room, ins_en;
  logic [TW-1:0] esel;

  // clipped report bounds
  logic [12:0]   eiu13, clip13, lim13;
  logic [6:0]    rl7, lim7;

  // output register
  logic          out_v_q, out_v_d;
  logic [9:0]    o_idx_d;
  logic [31:0]   o_call_d;
  logic [63:0]   o_time_d;
  logic          o_byt_d, o_empty_d, o_last_d;

  hep_ram #(.WIDTH(DW), .DEPTH(ENTRY_COUNT)) u_bank (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.init_busy = (st_q == ST_INIT);
  assign q_pop_o            = q_pop;
  assign out_free           = !out_v_q || !out_stall_i;
  assign out_valid_o        = out_v_q;

  assign nb_cur = (fwd_v_q && fwd_addr_q == nb_addr_q) ? fwd_data_q : ram_rdata;
  assign nb_new = {nb_cur[95:32] + {32'h0, nb_dur_q}, nb_cur[31:0] + 32'd1};

  assign eiu13  = {2'b00, entries_in_use_i};
  assign clip13 = (eiu13 > 13'(ENTRY_COUNT)) ? 13'(ENTRY_COUNT) : eiu13;
  assign rl7    = {2'b00, report_limit_i};
  assign lim7   = (rl7 > 7'(TOP_MAX)) ? 7'(TOP_MAX) : rl7;
  assign lim13  = ({6'b0, lim7} > clip13) ? clip13 : {6'b0, lim7};

  assign esel   = emit_q[TW-1:0];

  // insertion compare network, one entry per cycle
  always_comb begin
    key_in = timed_q ? ram_rdata[95:32] : {32'h0, ram_rdata[31:0]};
    room   = 1'b0;
    for (int j = 0; j < TOP_MAX; j++) begin
      ge[j] = (LW'(j) < fill_q) &&
              ((timed_q ? ttime_q[j] : {32'h0, tcall_q[j]}) >= key_in);
      if ((LW'(j) < lim_q) && !ge[j]) begin
        room = 1'b1;
      end
    end
    ge_prev[0] = 1'b1;
    sh_ord[0]  = '0;
    sh_call[0] = '0;
    sh_time[0] = '0;
    for (int j = 1; j < TOP_MAX; j++) begin
      ge_prev[j] = ge[j-1];
      sh_ord[j]  = tord_q[j-1];
      sh_call[j] = tcall_q[j-1];
      sh_time[j] = ttime_q[j-1];
    end
    ins_en = (st_q == ST_RANK) && rv_q && (key_in != '0) && room;
  end

  always_comb begin
    st_d      = st_q;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    lim_d     = lim_q;
    fill_d    = fill_q;
    emit_d    = emit_q;
    rv_d      = 1'b0;
    timed_d   = timed_q;
    nb_v_d    = 1'b0;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    o_idx_d   = '0;
    o_call_d  = '0;
    o_time_d  = '0;
    o_byt_d   = 1'b0;
    o_empty_d = 1'b1;
    o_last_d  = 1'b1;
    ram_raddr = (st_q == ST_IDLE) ? q_item_i.idx[IW-1:0] : addr_q[IW-1:0];
    ram_we    = nb_v_q;
    ram_waddr = nb_v_q ? nb_addr_q : addr_q[IW-1:0];
    ram_wdata = nb_v_q ? nb_new : '0;

    case (st_q)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (addr_q == CW'(ENTRY_COUNT - 1)) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_item_i.report == hep_pkg::OP_NOTE) begin
            q_pop  = 1'b1;
            nb_v_d = 1'b1;
          end else if (report_limit_i == '0) begin
            if (out_free) begin
              q_pop    = 1'b1;
              out_load = 1'b1;
            end
          end else begin
            q_pop   = 1'b1;
            cnt_d   = CW'(clip13);
            lim_d   = LW'(lim13);
            addr_d  = '0;
            timed_d = 1'b0;
            st_d    = ST_DETECT;
          end
        end
      end
      ST_DETECT, ST_RANK: begin
        if (addr_q < cnt_q) begin
          rv_d   = 1'b1;
          addr_d = addr_q + 1'b1;
        end
        if (st_q == ST_DETECT && rv_q && ram_rdata[95:32] != '0) begin
          timed_d = 1'b1;
        end
        if (ins_en && fill_q < lim_q) begin
          fill_d = fill_q + 1'b1;
        end
        if (addr_q == cnt_q && !rv_q) begin
          addr_d = '0;
          if (st_q == ST_DETECT) begin
            fill_d = '0;
            st_d   = ST_RANK;
          end else begin
            emit_d = '0;
            st_d   = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (fill_q == '0) begin
            st_d = ST_CLEAR;
          end else begin
            o_idx_d   = 10'(tord_q[esel]);
            o_call_d  = tcall_q[esel];
            o_time_d  = ttime_q[esel];
            o_byt_d   = timed_q;
            o_empty_d = 1'b0;
            o_last_d  = ((emit_q + 1'b1) == fill_q);
            emit_d    = emit_q + 1'b1;
            if ((emit_q + 1'b1) == fill_q) begin
              st_d = ST_CLEAR;
            end
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    out_v_d = out_load || (out_v_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_INIT;
      addr_q  <= '0;
      cnt_q   <= '0;
      lim_q   <= '0;
      fill_q  <= '0;
      emit_q  <= '0;
      rv_q    <= 1'b0;
      timed_q <= 1'b0;
      nb_v_q  <= 1'b0;
      fwd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q    <= st_d;
      addr_q  <= addr_d;
      cnt_q   <= cnt_d;
      lim_q   <= lim_d;
      fill_q  <= fill_d;
      emit_q  <= emit_d;
      rv_q    <= rv_d;
      timed_q <= timed_d;
      nb_v_q  <= nb_v_d;
      fwd_v_q <= nb_v_q;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nb_addr_q  <= q_item_i.idx[IW-1:0];
    nb_dur_q   <= q_item_i.dur;
    fwd_addr_q <= nb_addr_q;
    fwd_data_q <= nb_new;
    ridx_q     <= addr_q[IW-1:0];
    if (ins_en) begin
      for (int j = 0; j < TOP_MAX; j++) begin
        if (!ge[j]) begin
          if (ge_prev[j]) begin
            tord_q[j]  <= ridx_q;
            tcall_q[j] <= ram_rdata[31:0];
            ttime_q[j] <= ram_rdata[95:32];
          end else begin
            tord_q[j]  <= sh_ord[j];
            tcall_q[j] <= sh_call[j];
            ttime_q[j] <= sh_time[j];
          end
        end
      end
    end
    if (out_load) begin
      ranked_index_o   <= o_idx_d;
      call_delta_o     <= o_call_d;
      time_delta_o     <= o_time_d;
      ranked_by_time_o <= o_byt_d;
      empty_res_o      <= o_empty_d;
      last_o           <= o_last_d;
    end
  end

  `HEP_ASSERT_IMP(a_scan_no_note, clk_i, rst_ni, st_q == ST_DETECT, !nb_v_q)
  `HEP_ASSERT_IMP(a_fill_in_limit, clk_i, rst_ni, st_q == ST_EMIT, fill_q <= lim_q)
  `HEP_ASSERT_NXT(a_note_stage, clk_i, rst_ni, q_pop && !q_item_i.report, nb_v_q)
  `HEP_ASSERT_IMP(a_sweep_writes, clk_i, rst_ni, st_q == ST_CLEAR, ram_we && ram_wdata == '0)

endmodule
